/* hw/rtl/avc_pkg.sv */
// ----------------------------------------------------------------------------
// avc_pkg: shared types and constants of the alphabet Vigenere cipher unit
// Item layouts, operation and state codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package avc_pkg;

    localparam int ALPHABET_DEPTH_DEF = 128;
    localparam int KEY_DEPTH_DEF      = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_CONTIGUOUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH          = 2'd2;

    localparam logic [7:0] ALPHABET_SIZE_RST = 8'd26;
    localparam logic       CONTIGUOUS_RST    = 1'b0;
    localparam logic [6:0] KEY_LENGTH_RST    = 7'd1;

    typedef enum logic [1:0] {
        OP_LOAD_ALPHA = 2'd0,
        OP_LOAD_KEY   = 2'd1,
        OP_ENCRYPT    = 2'd2,
        OP_DECRYPT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_SEARCH,
        ST_CALC,
        ST_FETCH
    } state_t;

    typedef struct packed {
        op_t        operation;
        logic [6:0] table_index;
        logic [7:0] char_in;
        logic       message_start;
    } req_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_found;
    } rsp_item_t;

    // Memory strobes from the sequencer to the table store
    typedef struct packed {
        logic alpha_we;
        logic alpha_re;
        logic key_we;
        logic key_re;
    } mem_ctl_t;

endpackage

/* hw/rtl/avc_store.sv */
// ----------------------------------------------------------------------------
// avc_store: alphabet and key tables
// Two single-port synchronous memories with registered read.
// ----------------------------------------------------------------------------
module avc_store #(
    parameter int ALPHABET_DEPTH = 128,
    parameter int KEY_DEPTH      = 64,
    parameter int AW             = 7,
    parameter int KW             = 6
) (
    input  logic              clk,
    input  avc_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     alpha_addr,
    input  logic [KW-1:0]     key_addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        alpha_rdata,
    output logic [7:0]        key_rdata
);
    import avc_pkg::*;

    logic [7:0] alpha_mem [ALPHABET_DEPTH];
    logic [7:0] key_mem   [KEY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.alpha_we)
        begin
            alpha_mem[alpha_addr] <= wdata;
        end
        if (ctl.alpha_re)
        begin
            alpha_rdata <= alpha_mem[alpha_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[key_addr] <= wdata;
        end
        if (ctl.key_re)
        begin
            key_rdata <= key_mem[key_addr];
        end
    end

endmodule

/* hw/rtl/avc_ctrl.sv */
// ----------------------------------------------------------------------------
// avc_ctrl: cipher sequencer
// Runs loads, key lookup, alphabet search or offset math, and result fetch.
// ----------------------------------------------------------------------------
module avc_ctrl #(
    parameter int ALPHABET_DEPTH = 128,
    parameter int KEY_DEPTH      = 64,
    parameter int AW             = 7,
    parameter int KW             = 6,
    parameter int SW             = 8,
    parameter int KLW            = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 busy,
    input  avc_pkg::req_item_t   req,
    input  logic [SW-1:0]        eff_size,
    input  logic [KLW-1:0]       eff_klen,
    input  logic                 contiguous,
    output avc_pkg::mem_ctl_t    mem_ctl,
    output logic [AW-1:0]        alpha_addr,
    output logic [KW-1:0]        key_addr,
    output logic [7:0]           wdata,
    input  logic [7:0]           alpha_rdata,
    input  logic [7:0]           key_rdata,
    output logic                 res_valid,
    input  logic                 res_ready,
    output avc_pkg::rsp_item_t   res
);
    import avc_pkg::*;

    localparam int NW = SW + 1;

    state_t        state_reg, state_next;
    logic [KW-1:0] kp_reg, kp_next;
    logic [7:0]    ch_reg, ch_next;
    logic [7:0]    keych_reg, keych_next;
    logic          enc_reg, enc_next;
    logic [SW-1:0] issue_reg, issue_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] k_reg, k_next;
    logic          pf_reg, pf_next;
    logic          kf_reg, kf_next;

    logic [KLW-1:0] kp_use;
    logic [KLW-1:0] kp_inc;
    logic [7:0]     p_diff;
    logic [7:0]     k_diff;
    logic [NW-1:0]  pe, ke, se, sum, r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kp_reg        <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kp_reg        <= kp_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        keych_reg   <= keych_next;
        enc_reg     <= enc_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        p_reg       <= p_next;
        k_reg       <= k_next;
        pf_reg      <= pf_next;
        kf_reg      <= kf_next;
    end

    // Key position used by this item and the one after it
    always_comb
    begin
        if (req.message_start || (KLW'(kp_reg) >= eff_klen))
        begin
            kp_use = '0;
        end
        else
        begin
            kp_use = KLW'(kp_reg);
        end
        kp_inc = kp_use + KLW'(1);
        if (kp_inc >= eff_klen)
        begin
            kp_inc = '0;
        end
    end

    // Offsets from the first alphabet entry (contiguous alphabets)
    assign p_diff = ch_reg - alpha_rdata;
    assign k_diff = key_rdata - alpha_rdata;

    // Modular add or subtract of the two positions
    always_comb
    begin
        pe  = NW'(p_reg);
        ke  = NW'(k_reg);
        se  = NW'(eff_size);
        sum = pe + ke;
        if (enc_reg)
        begin
            r = (sum >= se) ? (sum - se) : sum;
        end
        else
        begin
            r = (pe >= ke) ? (pe - ke) : (pe + se - ke);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        ch_next        = ch_reg;
        keych_next     = keych_reg;
        enc_next       = enc_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        pf_next        = pf_reg;
        kf_next        = kf_reg;
        mem_ctl        = '0;
        alpha_addr     = '0;
        key_addr       = '0;
        wdata          = req.char_in;
        busy           = 1'b1;
        res_valid      = 1'b0;
        res.char_out   = pf_reg && kf_reg ? alpha_rdata : 8'd0;
        res.not_found  = !(pf_reg && kf_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (req_valid)
                begin
                    unique case (req.operation)
                        OP_LOAD_ALPHA:
                        begin
                            alpha_addr       = AW'(req.table_index);
                            mem_ctl.alpha_we = ({2'b0, req.table_index} < 9'(ALPHABET_DEPTH));
                        end
                        OP_LOAD_KEY:
                        begin
                            key_addr       = KW'(req.table_index);
                            mem_ctl.key_we =
                                (KLW'(req.table_index) < KLW'(KEY_DEPTH));
                        end
                        OP_ENCRYPT, OP_DECRYPT:
                        begin
                            // fetch the key character and the first alphabet entry
                            key_addr         = KW'(kp_use);
                            mem_ctl.key_re   = 1'b1;
                            alpha_addr       = '0;
                            mem_ctl.alpha_re = 1'b1;
                            kp_next          = KW'(kp_inc);
                            ch_next          = req.char_in;
                            enc_next         = (req.operation == OP_ENCRYPT);
                            state_next       = ST_KEY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_KEY:
            begin
                keych_next = key_rdata;
                if (contiguous)
                begin
                    pf_next    = (ch_reg >= alpha_rdata) &&
                                 ({1'b0, p_diff} < 9'(eff_size));
                    kf_next    = (key_rdata >= alpha_rdata) &&
                                 ({1'b0, k_diff} < 9'(eff_size));
                    p_next     = AW'(p_diff);
                    k_next     = AW'(k_diff);
                    state_next = ST_CALC;
                end
                else
                begin
                    pf_next    = 1'b0;
                    kf_next    = 1'b0;
                    issue_next = '0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // compare the entry read last cycle; first match wins
                if (cmp_valid_reg)
                begin
                    if (!pf_reg && (alpha_rdata == ch_reg))
                    begin
                        pf_next = 1'b1;
                        p_next  = cmp_idx_reg;
                    end
                    if (!kf_reg && (alpha_rdata == keych_reg))
                    begin
                        kf_next = 1'b1;
                        k_next  = cmp_idx_reg;
                    end
                end
                if ((issue_reg < eff_size) && !(pf_reg && kf_reg))
                begin
                    alpha_addr       = issue_reg[AW-1:0];
                    mem_ctl.alpha_re = 1'b1;
                    cmp_valid_next   = 1'b1;
                    cmp_idx_next     = issue_reg[AW-1:0];
                    issue_next       = issue_reg + SW'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_CALC;
                end
            end

            ST_CALC:
            begin
                alpha_addr       = r[AW-1:0];
                mem_ctl.alpha_re = pf_reg && kf_reg;
                state_next       = ST_FETCH;
            end

            ST_FETCH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/alphabet_vigenere_cipher_unit.sv */
// ----------------------------------------------------------------------------
// alphabet_vigenere_cipher_unit: Vigenere cipher over a loadable alphabet
//
// Usage:
//   req channel (req_valid/req_stall/req) takes one item at a time. A load
//   item writes one alphabet or key entry and gives no result. An encrypt
//   or decrypt item gives exactly one rsp item.
//   rsp channel (rsp_valid/rsp_stall/rsp) carries char_out and not_found.
//   A cipher item reads its key character and the first alphabet entry,
//   then works out the offsets (contiguous alphabet) or searches the
//   alphabet, then fetches the result into the output register.
//   The search runs through the single read port of the alphabet
//   memory, which returns one entry per cycle to the compare logic, and
//   ends early once both characters are found.
//   The output register parts the channels: a finished item waits there
//   while the sequencer returns to idle and takes the next request.
//   A stalled receiver holds the result; once a second result is ready
//   and the register is still full, the sequencer holds in fetch.
//   Reset clears the key position and the control state and loads the
//   registers with alphabet_size 26, contiguous off, key_length 1. The
//   tables are not cleared; load them before use.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once
//   and belong between items only.
// ----------------------------------------------------------------------------
module alphabet_vigenere_cipher_unit #(
    parameter int ALPHABET_DEPTH = avc_pkg::ALPHABET_DEPTH_DEF,
    parameter int KEY_DEPTH      = avc_pkg::KEY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  avc_pkg::req_item_t                req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output avc_pkg::rsp_item_t                rsp,
    input  logic                              cfg_write,
    input  logic [avc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import avc_pkg::*;

    localparam int AW  = $clog2(ALPHABET_DEPTH);
    localparam int KW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int SW  = $clog2(ALPHABET_DEPTH + 1);
    localparam int KLW = ($clog2(KEY_DEPTH + 1) > 7) ? $clog2(KEY_DEPTH + 1) : 7;

    // Configuration registers
    logic [7:0] alphabet_size_reg;
    logic       contiguous_reg;
    logic [6:0] key_length_reg;

    // Effective sizes after clamping
    logic [SW-1:0]  eff_size;
    logic [KLW-1:0] eff_klen;

    // Sequencer to store
    mem_ctl_t      mem_ctl;
    logic [AW-1:0] alpha_addr;
    logic [KW-1:0] key_addr;
    logic [7:0]    wdata;
    logic [7:0]    alpha_rdata;
    logic [7:0]    key_rdata;

    // Sequencer to output register
    logic       res_valid;
    logic       res_ready;
    rsp_item_t  res;
    logic       busy;

    logic       out_valid_reg;
    rsp_item_t  out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= ALPHABET_SIZE_RST;
            contiguous_reg    <= CONTIGUOUS_RST;
            key_length_reg    <= KEY_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ALPHABET_SIZE:       alphabet_size_reg <= cfg_data;
                CFG_ALPHABET_CONTIGUOUS: contiguous_reg    <= cfg_data[0];
                CFG_KEY_LENGTH:          key_length_reg    <= cfg_data[6:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Clamp size and key length: zero acts as one, oversize as the depth
    always_comb
    begin
        if (alphabet_size_reg == 8'd0)
        begin
            eff_size = SW'(1);
        end
        else if ({1'b0, alphabet_size_reg} > 9'(ALPHABET_DEPTH))
        begin
            eff_size = SW'(ALPHABET_DEPTH);
        end
        else
        begin
            eff_size = SW'(alphabet_size_reg);
        end

        if (key_length_reg == 7'd0)
        begin
            eff_klen = KLW'(1);
        end
        else if (KLW'(key_length_reg) > KLW'(KEY_DEPTH))
        begin
            eff_klen = KLW'(KEY_DEPTH);
        end
        else
        begin
            eff_klen = KLW'(key_length_reg);
        end
    end

    avc_ctrl #(
        .ALPHABET_DEPTH (ALPHABET_DEPTH),
        .KEY_DEPTH      (KEY_DEPTH),
        .AW             (AW),
        .KW             (KW),
        .SW             (SW),
        .KLW            (KLW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .busy        (busy),
        .req         (req),
        .eff_size    (eff_size),
        .eff_klen    (eff_klen),
        .contiguous  (contiguous_reg),
        .mem_ctl     (mem_ctl),
        .alpha_addr  (alpha_addr),
        .key_addr    (key_addr),
        .wdata       (wdata),
        .alpha_rdata (alpha_rdata),
        .key_rdata   (key_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    avc_store #(
        .ALPHABET_DEPTH (ALPHABET_DEPTH),
        .KEY_DEPTH      (KEY_DEPTH),
        .AW             (AW),
        .KW             (KW)
    ) u_store (
        .clk         (clk),
        .ctl         (mem_ctl),
        .alpha_addr  (alpha_addr),
        .key_addr    (key_addr),
        .wdata       (wdata),
        .alpha_rdata (alpha_rdata),
        .key_rdata   (key_rdata)
    );

    // Output register: load when empty or being drained this cycle
    assign res_ready = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign req_stall = busy;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // A cipher item keeps the sequencer busy in the next cycle
    a_cipher_busy : assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        (req.operation == OP_ENCRYPT || req.operation == OP_DECRYPT)
        |=> req_stall)
        else $error("cipher item accepted without entering busy");

    // A finished result holds until the output register takes it
    a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("pending result dropped");

    // An idle sequencer has no result pending
    a_idle_no_res : assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !res_valid)
        else $error("result pending while idle");

endmodule
